### src/tukey_window_value_top_assert.svh
// Assertion macros used by the block's checker.
`ifndef TUKEY_WINDOW_VALUE_TOP_ASSERT_SVH
`define TUKEY_WINDOW_VALUE_TOP_ASSERT_SVH

// Implication checked on the same edge.
`define TKW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a delayed consequent.
`define TKW_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

### src/tkw_pkg.sv
package tkw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = FRAC_BITS + 1;
  localparam int Q_BITS    = 30;                 // internal fraction precision
  localparam int V_W       = FRAC_BITS + 2;      // reduced cosine argument
  localparam int DIV_W     = V_W + Q_BITS;       // dividend bits = divider cells
  localparam int COS_W     = 32;
  localparam int RECIP_W   = 34;

  localparam int RECIP_TERMS = 5;
  localparam int COS_TERMS   = RECIP_TERMS + 1;  // last term halves

  // front + divider row + fold + angle + square + series terms + output
  localparam int PIPE_DEPTH = 1 + DIV_W + 1 + 2 + 2 * COS_TERMS + 1;

  localparam logic [FIELD_W-1:0] ONE_VAL  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FIELD_W-1:0] HALF_VAL = ONE_VAL >> 1;

  localparam logic [COS_W-1:0] Q30_ONE  = COS_W'(64'd1 << Q_BITS);
  localparam logic [COS_W-1:0] Q30_HALF = COS_W'(64'd1 << (Q_BITS - 1));
  localparam logic [COS_W-1:0] PI_Q30   = 32'd3373259426;

  localparam logic [COS_W-1:0] RND_BIAS  = COS_W'(64'd1 << (Q_BITS - 1 - FRAC_BITS));
  localparam int               RND_SHIFT = Q_BITS - FRAC_BITS;

  // floor(p / d) = (p * ceil(2^s / d)) >> s, exact for p < 2^32
  localparam logic [RECIP_W-1:0] RECIP [RECIP_TERMS] = '{
    RECIP_W'(((68'd1 << 40) + 68'd131) / 68'd132),
    RECIP_W'(((68'd1 << 39) + 68'd89) / 68'd90),
    RECIP_W'(((68'd1 << 38) + 68'd55) / 68'd56),
    RECIP_W'(((68'd1 << 37) + 68'd29) / 68'd30),
    RECIP_W'(((68'd1 << 36) + 68'd11) / 68'd12)
  };
  localparam int RECIP_SHIFT [RECIP_TERMS] = '{40, 39, 38, 37, 36};

  typedef struct packed {
    logic                 valid;
    logic                 flat;
    logic [FRAC_BITS-1:0] rem;
    logic [DIV_W-1:0]     work;
  } div_cell_t;

  typedef struct packed {
    logic             valid;
    logic             flat;
    logic             mirror;
    logic [COS_W-1:0] w;
    logic [COS_W-1:0] val;
  } cos_stage_t;

endpackage

### src/tukey_window_value_top.sv
// Tukey (tapered cosine) window value generator.
//
// Input: pulse start with position (unsigned Q1.16, 65536 = 1.0). A position
// is taken at every rising edge with start high and busy low; busy is high
// only while rst is asserted, so one position can be taken every cycle.
// Output: done is high for one cycle with window_value (Q1.16, 0..1.0).
// Results come out in input order, after passing through these stages:
// 1 front stage, 48 divider cells (one quotient bit each), a fold stage,
// angle and square multiplies, two stages per cosine series term (six
// terms) and the output rounding stage. Throughput is one item per cycle.
// The receiver cannot hold results off; none is needed, nothing stalls.
// Configuration: taper_fraction (alpha, Q1.16) is written by a transfer on
// taper_fraction_valid/taper_fraction_ready, clipped to 1..65536 on write.
// Write it only with no items in flight.
// Synchronous reset empties the pipeline and sets alpha to 0.5.
module tukey_window_value_top import tkw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] position,
  input  logic               taper_fraction_valid,
  output logic               taper_fraction_ready,
  input  logic [FIELD_W-1:0] taper_fraction,
  output logic               done,
  output logic [FIELD_W-1:0] window_value
);

  logic               accept;
  logic [FIELD_W-1:0] alpha;

  // front stage signals
  logic [V_W-1:0] x2;
  logic [V_W-1:0] a_ext;
  logic [V_W-1:0] two_one;
  logic           attack;
  logic           release_reg;
  logic [V_W-1:0] arg;
  div_cell_t      front_next;

  // divider row
  div_cell_t front;
  div_cell_t div_bus [DIV_W+1];

  // fold stage
  div_cell_t         div_out;
  logic [Q_BITS:0]   frac;
  logic [Q_BITS:0]   q30_one_w;
  logic              mirror;
  logic [Q_BITS:0]   folded;
  cos_stage_t        fold_next;
  cos_stage_t        fold;

  // output stage
  cos_stage_t       cos_out;
  logic [COS_W-1:0] g_sum;
  logic [COS_W-1:0] g_clamp;
  logic [COS_W-1:0] g_side;
  logic [COS_W-1:0] g_rnd;
  logic [FIELD_W-1:0] value_next;

  assign busy                 = rst;
  assign accept               = start && !busy;
  assign taper_fraction_ready = !rst;

  // alpha register, clipped to one LSB .. 1.0 as it is written
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= HALF_VAL;
    end else if (taper_fraction_valid && taper_fraction_ready) begin
      if (taper_fraction == '0) begin
        alpha <= FIELD_W'(1);
      end else if (taper_fraction > ONE_VAL) begin
        alpha <= ONE_VAL;
      end else begin
        alpha <= taper_fraction;
      end
    end
  end

  // Front: classify the region and form the cosine argument v.
  // Attack: v = alpha - 2x. Release: v = 2x + alpha - 2.0, reduced later.
  always_comb begin
    x2      = {position, 1'b0};
    a_ext   = V_W'(alpha);
    two_one = V_W'(ONE_VAL) << 1;
    attack  = (x2 < a_ext);
    release_reg = (x2 > two_one - a_ext);
    arg     = attack ? a_ext - x2 : x2 + a_ext - two_one;

    front_next.valid = accept;
    front_next.flat  = !attack && !release_reg;
    front_next.rem   = '0;
    front_next.work  = {arg, {Q_BITS{1'b0}}};
  end

  // valid is clear under reset since accept needs busy low
  always_ff @(posedge clk) begin
    front <= front_next;
  end

  assign div_bus[0] = front;

  // Long division of v * 2^30 by alpha, one quotient bit per cell.
  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    tkw_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .alpha (alpha),
      .din   (div_bus[i]),
      .dout  (div_bus[i+1])
    );
  end

  // Fold: quotient bit 30 is the parity of floor(v/alpha). An odd period
  // mirrors the remainder, so f = 1 - ceil(frac), else f = floor(frac).
  // Then f above 1/2 is mirrored using g(f) = 1 - g(1-f).
  always_comb begin
    div_out   = div_bus[DIV_W];
    q30_one_w = (Q_BITS + 1)'(Q30_ONE);
    if (div_out.work[Q_BITS]) begin
      frac = q30_one_w - {1'b0, div_out.work[Q_BITS-1:0]}
             - (Q_BITS + 1)'(div_out.rem != '0);
    end else begin
      frac = {1'b0, div_out.work[Q_BITS-1:0]};
    end
    mirror = (frac > (Q_BITS + 1)'(Q30_HALF));
    folded = mirror ? q30_one_w - frac : frac;

    fold_next.valid  = div_out.valid && !rst;
    fold_next.flat   = div_out.flat;
    fold_next.mirror = mirror;
    fold_next.w      = '0;
    fold_next.val    = COS_W'(folded);
  end

  always_ff @(posedge clk) begin
    fold <= fold_next;
  end

  tkw_cos u_cos (
    .clk  (clk),
    .rst  (rst),
    .din  (fold),
    .dout (cos_out)
  );

  // Output: g = (1 + cos)/2, unmirror, round half up to 16 bits, clamp; flat gives 1.0.
  always_comb begin
    g_sum   = (Q30_ONE + cos_out.val) >> 1;
    g_clamp = (g_sum > Q30_ONE) ? Q30_ONE : g_sum;
    g_side  = cos_out.mirror ? Q30_ONE - g_clamp : g_clamp;
    g_rnd   = (g_side + RND_BIAS) >> RND_SHIFT;
    if (cos_out.flat || (g_rnd > COS_W'(ONE_VAL))) begin
      value_next = ONE_VAL;
    end else begin
      value_next = FIELD_W'(g_rnd);
    end
  end

  always_ff @(posedge clk) begin
    window_value <= value_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cos_out.valid;
    end
  end

endmodule

### src/tkw_div_cell.sv
// One restoring division step: shift in a dividend bit, trial subtract.
module tkw_div_cell import tkw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [FIELD_W-1:0] alpha,
  input  div_cell_t          din,
  output div_cell_t          dout
);

  logic [FIELD_W-1:0] trial;
  logic [FIELD_W-1:0] diff;
  logic               ge;
  div_cell_t          cell_next;

  always_comb begin
    trial = {din.rem, din.work[DIV_W-1]};
    diff  = trial - alpha;
    ge    = (trial >= alpha);
    cell_next       = din;
    cell_next.valid = din.valid && !rst;
    cell_next.rem   = FRAC_BITS'(ge ? diff : trial);
    cell_next.work  = {din.work[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    dout <= cell_next;
  end

endmodule

### src/tkw_cos.sv
// cos(pi*f) for f in 0..1/2, Q2.30: angle, square, then nested series terms.
module tkw_cos import tkw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cos_stage_t din,
  output cos_stage_t dout
);

  cos_stage_t  s_ang;
  cos_stage_t  s_w;
  cos_stage_t  ang_next;
  cos_stage_t  w_next;
  cos_stage_t  sa [COS_TERMS];
  cos_stage_t  sb [COS_TERMS];
  logic [63:0] ang_prod;
  logic [63:0] w_prod;

  assign ang_prod = 64'(din.val) * 64'(PI_Q30);
  assign w_prod   = 64'(s_ang.val) * 64'(s_ang.val);

  always_comb begin
    ang_next       = din;
    ang_next.valid = din.valid && !rst;
    ang_next.val   = COS_W'(ang_prod >> Q_BITS);
  end

  always_ff @(posedge clk) begin
    s_ang <= ang_next;
  end

  always_comb begin
    w_next       = s_ang;
    w_next.valid = s_ang.valid && !rst;
    w_next.w     = COS_W'(w_prod >> Q_BITS);
    w_next.val   = Q30_ONE;
  end

  always_ff @(posedge clk) begin
    s_w <= w_next;
  end

  for (genvar k = 0; k < COS_TERMS; k++) begin : g_term
    cos_stage_t       tin;
    cos_stage_t       a_next;
    cos_stage_t       b_next;
    logic [63:0]      a_prod;
    logic [COS_W-1:0] sub;

    if (k == 0) begin : g_first
      assign tin = s_w;
    end else begin : g_rest
      assign tin = sb[k-1];
    end

    assign a_prod = 64'(tin.w) * 64'(tin.val);

    // w * t
    always_comb begin
      a_next       = tin;
      a_next.valid = tin.valid && !rst;
      a_next.val   = COS_W'(a_prod >> Q_BITS);
    end

    always_ff @(posedge clk) begin
      sa[k] <= a_next;
    end

    if (k < RECIP_TERMS) begin : g_recip
      logic [COS_W+RECIP_W-1:0] b_prod;
      assign b_prod = (COS_W + RECIP_W)'(sa[k].val) * (COS_W + RECIP_W)'(RECIP[k]);
      assign sub    = COS_W'(b_prod >> RECIP_SHIFT[k]);
    end else begin : g_half
      assign sub = sa[k].val >> 1;
    end

    // t = 1 - w*t/d, floored at zero
    always_comb begin
      b_next       = sa[k];
      b_next.valid = sa[k].valid && !rst;
      b_next.val   = (sub > Q30_ONE) ? '0 : Q30_ONE - sub;
    end

    always_ff @(posedge clk) begin
      sb[k] <= b_next;
    end
  end

  assign dout = sb[COS_TERMS-1];

endmodule

### src/tkw_chk.sv
// Port-level checks for the window generator.
`include "tukey_window_value_top_assert.svh"

module tkw_chk import tkw_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [FIELD_W-1:0] position,
  input logic               done,
  input logic [FIELD_W-1:0] window_value
);

  // every transfer in is followed by a result
  `TKW_ASSERT_DELAY(a_latency, start && !busy, PIPE_DEPTH, done, "result missing after latency")

  // no result without a matching transfer in
  `TKW_ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, PIPE_DEPTH), "result without input")

  // mid-window is always in the flat part, whatever alpha
  `TKW_ASSERT_DELAY(a_mid_flat,
                    start && !busy && position == HALF_VAL,
                    PIPE_DEPTH, window_value == ONE_VAL, "mid-window value not 1.0")

  // gain never exceeds 1.0
  `TKW_ASSERT_IMPL(a_range, done, window_value <= ONE_VAL, "window value above 1.0")

endmodule

bind tukey_window_value_top tkw_chk u_tkw_chk (.*);
